[src/hftw_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package hftw_pkg;

    // Fixed field widths
    localparam int OP_W     = 2;
    localparam int SYM_W    = 8;
    localparam int PARENT_W = 9;
    localparam int BYTE_W   = 8;
    localparam int VBITS_W  = 4;

    // Bits walked in a full data byte
    localparam logic [VBITS_W-1:0] BYTE_BITS = 4'd8;

    // Operation codes
    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 2'd0,
        OP_DECODE = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LINK,
        ST_STEP,
        ST_FLUSH
    } state_t;

endpackage

`default_nettype wire

[src/hftw_link_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

// Single write port, single registered read port
module hftw_link_ram #(
    parameter int  DEPTH = 512,
    parameter int  DW    = 38,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic          aclk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [DW-1:0] wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[src/huffman_tree_walk_decoder.sv]
`timescale 1ns / 1ps
`default_nettype none

// Append: store the node, then read-modify-write the parent's links.
// Decode: the accept, one step per walked bit (up to 8), then a closing state;
//   each bit reads link memory or a root copy; a step waits while the result
//   channel stalls. Clear and unused operation: handled in the idle state alone.
// Reset clears node count and walk position; the link memory is not cleared,
//   entries at or above the node count are never used.
module huffman_tree_walk_decoder #(
    parameter int MAX_NODES = 512
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [hftw_pkg::OP_W-1:0]         s_operation,
    input  wire logic                              s_node_is_internal,
    input  wire logic [hftw_pkg::SYM_W-1:0]        s_node_symbol,
    input  wire logic [hftw_pkg::PARENT_W-1:0]     s_node_parent,
    input  wire logic [hftw_pkg::BYTE_W-1:0]       s_data_byte,
    input  wire logic                              s_is_last_byte,
    input  wire logic [hftw_pkg::VBITS_W-1:0]      s_valid_bits,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic      [hftw_pkg::SYM_W-1:0]        m_decoded_symbol,
    output logic                                   m_walk_error,
    output logic                                   m_last_of_byte
);

    import hftw_pkg::*;

    localparam int IW   = $clog2(MAX_NODES);
    localparam int CW   = $clog2(MAX_NODES + 1);
    localparam int CMPW = (CW > PARENT_W) ? CW : PARENT_W;

    // One child link: everything the walk needs about the child itself
    typedef struct packed {
        logic             internal;
        logic [SYM_W-1:0] sym;
        logic [IW-1:0]    idx;
    } child_t;

    typedef struct packed {
        logic   has_one;
        child_t one;
        logic   has_zero;
        child_t zero;
    } link_t;

    localparam int LINK_W = $bits(link_t);

    state_t state_reg, state_next;

    logic [CW-1:0]       count_reg, count_next;
    logic [IW-1:0]       cur_reg, cur_next;
    logic                from_root_reg, from_root_next;
    link_t               root_link_reg, root_link_next;
    logic                root_int_reg, root_int_next;
    logic [BYTE_W-1:0]   byte_reg, byte_next;
    logic [VBITS_W-1:0]  bits_left_reg, bits_left_next;
    logic                last_reg, last_next;
    logic                node_int_reg, node_int_next;
    logic [SYM_W-1:0]    node_sym_reg, node_sym_next;
    logic [PARENT_W-1:0] parent_reg, parent_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [SYM_W-1:0]    pend_sym_reg, pend_sym_next;
    logic                pend_err_reg, pend_err_next;
    logic                m_valid_reg, m_valid_next;
    logic [SYM_W-1:0]    m_sym_reg, m_sym_next;
    logic                m_err_reg, m_err_next;
    logic                m_last_reg, m_last_next;

    logic              wr_en;
    logic [IW-1:0]     wr_addr;
    link_t             wr_rec;
    logic              rd_en;
    logic [IW-1:0]     rd_addr;
    logic [LINK_W-1:0] rd_data;

    logic               s_accept;
    logic               can_emit;
    logic               full;
    logic [VBITS_W-1:0] s_nbits;
    logic [CMPW-1:0]    s_parent_ext;
    logic [CMPW-1:0]    parent_ext;
    logic [CMPW-1:0]    k_ext;
    logic               do_link;
    link_t              rd_rec;
    link_t              cur_rec;
    link_t              upd_rec;
    child_t             new_child;
    child_t             sel;
    logic               node_ok;
    logic               bit_val;
    logic               step_ok;
    logic               step_hit;
    logic               step_go;

    hftw_link_ram #(
        .DEPTH (MAX_NODES),
        .DW    (LINK_W)
    ) u_link_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_rec),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Handshake and shared terms
    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign can_emit = !m_valid_reg || m_ready;
    assign full     = (count_reg == CW'(MAX_NODES));

    assign s_nbits = !s_is_last_byte ? BYTE_BITS :
                     (s_valid_bits > BYTE_BITS) ? BYTE_BITS : s_valid_bits;

    assign s_parent_ext = CMPW'(s_node_parent);
    assign parent_ext   = CMPW'(parent_reg);
    assign k_ext        = CMPW'(count_reg);
    assign do_link      = (count_reg != '0) && (parent_ext < k_ext);

    assign new_child = '{internal: node_int_reg, sym: node_sym_reg,
                         idx: count_reg[IW-1:0]};

    // Parent record with the new child linked in
    always_comb begin
        upd_rec = rd_rec;
        if (!rd_rec.has_one) begin
            upd_rec.has_one = 1'b1;
            upd_rec.one     = new_child;
        end else begin
            upd_rec.has_zero = 1'b1;
            upd_rec.zero     = new_child;
        end
    end

    // One tree step on the current bit
    assign rd_rec   = link_t'(rd_data);
    assign cur_rec  = from_root_reg ? root_link_reg : rd_rec;
    assign node_ok  = (cur_reg != '0) || ((count_reg != '0) && root_int_reg);
    assign bit_val  = byte_reg[BYTE_W-1];
    assign sel      = bit_val ? cur_rec.one : cur_rec.zero;
    assign step_ok  = node_ok && (bit_val ? cur_rec.has_one : cur_rec.has_zero);
    assign step_hit = !step_ok || !sel.internal;
    assign step_go  = !(step_hit && pend_valid_reg && !can_emit);

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    case (op_t'(s_operation))
                        OP_APPEND: if (!full) state_next = ST_LINK;
                        OP_DECODE: state_next = (s_nbits == '0) ? ST_FLUSH : ST_STEP;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_LINK:  state_next = ST_IDLE;
            ST_STEP: begin
                if (step_go && (bits_left_reg == VBITS_W'(1))) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!pend_valid_reg || can_emit) state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Datapath and memory control
    always_comb begin
        count_next      = count_reg;
        cur_next        = cur_reg;
        from_root_next  = from_root_reg;
        root_link_next  = root_link_reg;
        root_int_next   = root_int_reg;
        byte_next       = byte_reg;
        bits_left_next  = bits_left_reg;
        last_next       = last_reg;
        node_int_next   = node_int_reg;
        node_sym_next   = node_sym_reg;
        parent_next     = parent_reg;
        pend_valid_next = pend_valid_reg;
        pend_sym_next   = pend_sym_reg;
        pend_err_next   = pend_err_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_sym_next      = m_sym_reg;
        m_err_next      = m_err_reg;
        m_last_next     = m_last_reg;
        wr_en           = 1'b0;
        wr_addr         = count_reg[IW-1:0];
        wr_rec          = '0;
        rd_en           = 1'b0;
        rd_addr         = cur_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    byte_next      = s_data_byte;
                    bits_left_next = s_nbits;
                    last_next      = s_is_last_byte;
                    node_int_next  = s_node_is_internal;
                    node_sym_next  = s_node_symbol;
                    parent_next    = s_node_parent;
                    case (op_t'(s_operation))
                        OP_APPEND: begin
                            if (!full) begin
                                // fresh node without children; fetch the parent
                                wr_en   = 1'b1;
                                wr_addr = count_reg[IW-1:0];
                                wr_rec  = '0;
                                rd_en   = 1'b1;
                                rd_addr = s_parent_ext[IW-1:0];
                                if (count_reg == '0) begin
                                    root_link_next = '0;
                                    root_int_next  = s_node_is_internal;
                                end
                            end
                        end
                        OP_DECODE: begin
                            rd_en          = 1'b1;
                            rd_addr        = cur_reg;
                            from_root_next = 1'b0;
                        end
                        OP_CLEAR: begin
                            count_next = '0;
                            cur_next   = '0;
                        end
                        default: ;
                    endcase
                end
            end

            ST_LINK: begin
                if (do_link) begin
                    wr_en   = 1'b1;
                    wr_addr = parent_ext[IW-1:0];
                    wr_rec  = upd_rec;
                    if (parent_ext == '0) root_link_next = upd_rec;
                end
                count_next = count_reg + CW'(1);
            end

            ST_STEP: begin
                if (step_go) begin
                    byte_next      = {byte_reg[BYTE_W-2:0], 1'b0};
                    bits_left_next = bits_left_reg - VBITS_W'(1);
                    if (step_hit) begin
                        // older result is not the byte's last: hand it out
                        if (pend_valid_reg) begin
                            m_valid_next = 1'b1;
                            m_sym_next   = pend_sym_reg;
                            m_err_next   = pend_err_reg;
                            m_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_sym_next   = step_ok ? sel.sym : '0;
                        pend_err_next   = !step_ok;
                        cur_next        = '0;
                        from_root_next  = 1'b1;
                    end else begin
                        cur_next       = sel.idx;
                        rd_en          = 1'b1;
                        rd_addr        = sel.idx;
                        from_root_next = 1'b0;
                    end
                    // end of stream drops any partial code
                    if ((bits_left_reg == VBITS_W'(1)) && last_reg) cur_next = '0;
                end
            end

            ST_FLUSH: begin
                if (pend_valid_reg && can_emit) begin
                    m_valid_next    = 1'b1;
                    m_sym_next      = pend_sym_reg;
                    m_err_next      = pend_err_reg;
                    m_last_next     = 1'b1;
                    pend_valid_next = 1'b0;
                end
                if (last_reg) cur_next = '0;
            end

            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            cur_reg        <= '0;
            from_root_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            cur_reg        <= cur_next;
            from_root_reg  <= from_root_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        root_link_reg <= root_link_next;
        root_int_reg  <= root_int_next;
        byte_reg      <= byte_next;
        bits_left_reg <= bits_left_next;
        last_reg      <= last_next;
        node_int_reg  <= node_int_next;
        node_sym_reg  <= node_sym_next;
        parent_reg    <= parent_next;
        pend_sym_reg  <= pend_sym_next;
        pend_err_reg  <= pend_err_next;
        m_sym_reg     <= m_sym_next;
        m_err_reg     <= m_err_next;
        m_last_reg    <= m_last_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_decoded_symbol = m_sym_reg;
    assign m_walk_error     = m_err_reg;
    assign m_last_of_byte   = m_last_reg;

endmodule

`default_nettype wire

[src/hftw_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module hftw_checker (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              s_valid,
    input wire logic                              s_ready,
    input wire logic [hftw_pkg::OP_W-1:0]         s_operation,
    input wire logic                              s_node_is_internal,
    input wire logic [hftw_pkg::SYM_W-1:0]        s_node_symbol,
    input wire logic [hftw_pkg::PARENT_W-1:0]     s_node_parent,
    input wire logic [hftw_pkg::BYTE_W-1:0]       s_data_byte,
    input wire logic                              s_is_last_byte,
    input wire logic [hftw_pkg::VBITS_W-1:0]      s_valid_bits,
    input wire logic                              m_valid,
    input wire logic                              m_ready,
    input wire logic [hftw_pkg::SYM_W-1:0]        m_decoded_symbol,
    input wire logic                              m_walk_error,
    input wire logic                              m_last_of_byte
);

    import hftw_pkg::*;

    logic s_xfer;
    assign s_xfer = s_valid && s_ready;

    // Stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_decoded_symbol)
            && $stable(m_walk_error) && $stable(m_last_of_byte))
        else $error("result changed while stalled");

    // Error results carry no symbol
    a_err_sym: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_walk_error |-> m_decoded_symbol == '0)
        else $error("error result with nonzero symbol");

    // Append, clear and unused operations never create a result
    a_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer && !m_valid && (s_operation != OP_DECODE) |=> !m_valid)
        else $error("result after a non-decode transfer");

    // A decode transfer drops ready, keeping the input busy
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer && (s_operation == OP_DECODE) |=> !s_ready)
        else $error("ready right after a decode transfer");

endmodule

bind huffman_tree_walk_decoder hftw_checker u_hftw_checker (.*);

`default_nettype wire
